### design/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg: shared types and constants for the bounded array list
// Sizes, request and status codes, and the structs that pass between
// the sequencer and the top level.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 4;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_SEARCH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  // RAM access issued by the sequencer
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

  // Result fields of one request
  typedef struct packed {
    status_t          status;
    logic             found;
    logic [POS_W-1:0] found_position;
  } res_t;

endpackage

### design/bal_ram.sv
// ----------------------------------------------------------------------------
// bal_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/bal_seq.sv
// ----------------------------------------------------------------------------
// bal_seq: request sequencer for the bounded array list
// Walks the entry RAM one element at a time to shift entries up or down
// or to compare them against the searched value, and keeps the count.
// ----------------------------------------------------------------------------
module bal_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    req_type,
  input  logic [bal_pkg::POS_W-1:0]     position,
  input  logic [31:0]                   data_value,
  input  logic [bal_pkg::DATA_WIDTH-1:0] rd_data,
  output logic                          busy,
  output logic                          done,
  output bal_pkg::ram_req_t             ram_req,
  output bal_pkg::res_t                 res,
  output logic [bal_pkg::CNT_W-1:0]     count
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_PUT  = 5'b01000,
    S_CMP  = 5'b10000
  } state_t;

  state_t                          state, state_next;
  bal_pkg::req_t                   req, req_next;
  logic [bal_pkg::IDX_W-1:0]       pos, pos_next;
  logic [bal_pkg::IDX_W-1:0]       idx, idx_next;
  logic [bal_pkg::DATA_WIDTH-1:0]  val, val_next;
  logic [bal_pkg::CNT_W-1:0]       count_next;
  logic                            done_next;
  bal_pkg::res_t                   res_next;
  logic                            accept;
  logic                            full;
  logic [bal_pkg::CNT_W-1:0]       pos_in_ext;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign full       = (count == bal_pkg::CNT_W'(bal_pkg::CAPACITY));
  assign pos_in_ext = bal_pkg::CNT_W'(position);

  // sequencer next-state and RAM control
  always_comb begin
    state_next  = state;
    req_next    = req;
    pos_next    = pos;
    idx_next    = idx;
    val_next    = val;
    count_next  = count;
    done_next   = 1'b0;
    res_next    = res;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx;
    ram_req.wdata = rd_data;
    ram_req.raddr = idx;

    case (state)
      S_IDLE: begin
        if (accept) begin
          req_next = bal_pkg::req_t'(req_type);
          pos_next = bal_pkg::IDX_W'(position);
          val_next = data_value[bal_pkg::DATA_WIDTH-1:0];
          res_next.found          = 1'b0;
          res_next.found_position = '0;
          res_next.status         = bal_pkg::ST_DONE;
          case (bal_pkg::req_t'(req_type))
            bal_pkg::REQ_APPEND: begin
              done_next = 1'b1;
              if (full) begin
                res_next.status = bal_pkg::ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count[bal_pkg::IDX_W-1:0];
                ram_req.wdata = data_value[bal_pkg::DATA_WIDTH-1:0];
                count_next    = count + 1'b1;
              end
            end
            bal_pkg::REQ_INSERT: begin
              if (full) begin
                res_next.status = bal_pkg::ST_FULL;
                done_next       = 1'b1;
              end else if (pos_in_ext >= count) begin
                res_next.status = bal_pkg::ST_BADPOS;
                done_next       = 1'b1;
              end else begin
                idx_next   = count[bal_pkg::IDX_W-1:0];
                state_next = S_RD;
              end
            end
            bal_pkg::REQ_REMOVE: begin
              if (pos_in_ext >= count) begin
                res_next.status = bal_pkg::ST_BADPOS;
                done_next       = 1'b1;
              end else if (pos_in_ext + 1'b1 == count) begin
                count_next = count - 1'b1;
                done_next  = 1'b1;
              end else begin
                idx_next   = bal_pkg::IDX_W'(position);
                state_next = S_RD;
              end
            end
            default: begin
              if (count == '0) begin
                done_next = 1'b1;
              end else begin
                idx_next   = '0;
                state_next = S_RD;
              end
            end
          endcase
        end
      end

      // issue the read of the element to move or compare
      S_RD: begin
        case (req)
          bal_pkg::REQ_INSERT: ram_req.raddr = idx - 1'b1;
          bal_pkg::REQ_REMOVE: ram_req.raddr = idx + 1'b1;
          default:             ram_req.raddr = idx;
        endcase
        state_next = (req == bal_pkg::REQ_SEARCH) ? S_CMP : S_WR;
      end

      // move the element just read one place up or down
      S_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx;
        ram_req.wdata = rd_data;
        if (req == bal_pkg::REQ_INSERT) begin
          idx_next   = idx - 1'b1;
          state_next = (idx - 1'b1 == pos) ? S_PUT : S_RD;
        end else begin
          idx_next = idx + 1'b1;
          if (bal_pkg::CNT_W'(idx) + bal_pkg::CNT_W'(2) == count) begin
            count_next = count - 1'b1;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end

      // drop the inserted value into the opened slot
      S_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos;
        ram_req.wdata = val;
        count_next    = count + 1'b1;
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end

      // compare the element just read against the searched value
      S_CMP: begin
        if (rd_data == val) begin
          res_next.found          = 1'b1;
          res_next.found_position = bal_pkg::POS_W'(idx);
          done_next               = 1'b1;
          state_next              = S_IDLE;
        end else if (bal_pkg::CNT_W'(idx) + 1'b1 == count) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req <= req_next;
    pos <= pos_next;
    idx <= idx_next;
    val <= val_next;
    res <= res_next;
  end

endmodule

### design/bounded_array_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_array_list_unit: fixed-capacity ordered list of data words
// Appends, inserts, removes and searches over a 16-entry RAM-held list.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a rising edge with start high and busy low:
//   req_type selects append, insert, remove or search; position and
//   data_value are its operands. busy stays high while the request runs.
//   The result shows for exactly one cycle with done high: status, found,
//   found_position, and entry_count, list_empty, list_full after the request.
//   The receiver cannot stall; it must take the result in that cycle.
// Sequencing: each element moved or compared takes a RAM read and then
//   a write or a compare. Append, refused and trivial requests finish
//   without walking the RAM. Insert shifts entries from the end up one
//   place down to p, then writes the value at p; remove shifts entries
//   above p down one place; search compares from entry 0 to a hit or the end.
//   A new request may transfer in the cycle done is high.
// Reset: clears the count, so the list is empty; entry contents are not
//   cleared and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_array_list_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                req_type,
  input  logic [3:0]                position,
  input  logic [31:0]               data_value,
  output logic                      busy,
  output logic                      done,
  output logic [1:0]                status,
  output logic                      found,
  output logic [3:0]                found_position,
  output logic [4:0]                entry_count,
  output logic                      list_empty,
  output logic                      list_full
);

  bal_pkg::ram_req_t              ram_req;
  bal_pkg::res_t                  res;
  logic [bal_pkg::DATA_WIDTH-1:0] rd_data;
  logic [bal_pkg::CNT_W-1:0]      count;

  // request sequencer
  bal_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .position   (position),
    .data_value (data_value),
    .rd_data    (rd_data),
    .busy       (busy),
    .done       (done),
    .ram_req    (ram_req),
    .res        (res),
    .count      (count)
  );

  // entry storage
  bal_ram #(
    .WIDTH (bal_pkg::DATA_WIDTH),
    .DEPTH (bal_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // result and status outputs
  assign status         = res.status;
  assign found          = res.found;
  assign found_position = res.found_position;
  assign entry_count    = 5'(count);
  assign list_empty     = (count == '0);
  assign list_full      = (count == bal_pkg::CNT_W'(bal_pkg::CAPACITY));

endmodule

### design/bal_checker.sv
// ----------------------------------------------------------------------------
// bal_checker: port-level checks for the bounded array list
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
module bal_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic       found,
  input logic [3:0] found_position,
  input logic [4:0] entry_count
);

  // an accepted request either runs or finishes at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted request neither busy nor done");

  // a hit is a completed search inside the occupied range
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    done && found |-> status == bal_pkg::ST_DONE &&
                      {1'b0, found_position} < entry_count)
    else $error("found result outside occupied entries");

  // the count moves only with a result
  a_count_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && entry_count != $past(entry_count) |-> done)
    else $error("entry count changed without a result");

  // a refused request leaves the count alone
  a_refused_keeps_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && done && status != bal_pkg::ST_DONE |->
      entry_count == $past(entry_count))
    else $error("refused request changed entry count");

endmodule

bind bounded_array_list_unit bal_checker u_bal_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .found          (found),
  .found_position (found_position),
  .entry_count    (entry_count)
);
